[hdl/cnt_pkg.sv]
// Package: lane types, widths and fixed-point helper functions for node transform composition.
package cnt_pkg;

    localparam int LANE_W = 16;

    typedef logic signed [15:0] t_lane;

    typedef struct packed {
        logic valid;
        logic has_parent;
        logic inh_ori;
        logic inh_scl;
    } t_ctrl;

    // round half up: add half LSB then arithmetic shift (floor)
    function automatic logic signed [47:0] rnd14(input logic signed [47:0] v);
        logic signed [47:0] t;
        begin
            t = v + 48'sd8192;
            rnd14 = t >>> 14;
        end
    endfunction

    function automatic logic signed [47:0] rnd8(input logic signed [47:0] v);
        logic signed [47:0] t;
        begin
            t = v + 48'sd128;
            rnd8 = t >>> 8;
        end
    endfunction

    function automatic logic [16:0] sat16(input logic signed [47:0] v);
        begin
            if (v > 48'sd32767) begin
                sat16 = {1'b1, 16'h7fff};
            end else if (v < -48'sd32768) begin
                sat16 = {1'b1, 16'h8000};
            end else begin
                sat16 = {1'b0, v[15:0]};
            end
        end
    endfunction

endpackage

[hdl/compose_node_transform_core.sv]
// One transaction is accepted every cycle; start passes through control registers r_c1 to r_c7 to o_done.
// Throughput is set by the fully pipelined multiplier stages: busy is never raised.
// The result is shown for one cycle on o_done; the receiver cannot stall.
// Reset (i_rst_n low, synchronous) clears all valid bits; payload registers are not reset.
// Top level: node world-transform composition pipeline.
module compose_node_transform_core
    import cnt_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         start,
    output logic         busy,
    input  logic         i_has_parent,
    input  logic         i_inherit_orientation,
    input  logic         i_inherit_scale,
    input  logic [63:0]  i_local_orientation,
    input  logic [47:0]  i_local_scale,
    input  logic [47:0]  i_local_position,
    input  logic [63:0]  i_parent_orientation,
    input  logic [47:0]  i_parent_scale,
    input  logic [47:0]  i_parent_position,
    output logic         o_done,
    output logic [63:0]  o_world_orientation,
    output logic [47:0]  o_world_scale,
    output logic [47:0]  o_world_position,
    output logic         o_overflow
);

    t_ctrl c_in, c_mid;
    logic [63:0] lo, po, wo;
    logic [47:0] ls, lp, pp, ws;
    logic [1:0]  ov;
    logic signed [31:0] s [3];

    assign busy = 1'b0;
    assign c_in = '{valid: start, has_parent: i_has_parent,
                    inh_ori: i_inherit_orientation, inh_scl: i_inherit_scale};

    cnt_prod u_prod (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctrl(c_in),
        .i_lo(i_local_orientation), .i_ls(i_local_scale), .i_lp(i_local_position),
        .i_po(i_parent_orientation), .i_ps(i_parent_scale), .i_pp(i_parent_position),
        .o_ctrl(c_mid), .o_lo(lo), .o_ls(ls), .o_lp(lp), .o_po(po), .o_pp(pp),
        .o_wo(wo), .o_ws(ws), .o_ovf(ov), .o_s(s)
    );

    cnt_rot u_rot (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctrl(c_mid),
        .i_lo(lo), .i_ls(ls), .i_lp(lp), .i_po(po), .i_pp(pp),
        .i_wo(wo), .i_ws(ws), .i_ovf(ov), .i_s(s),
        .o_valid(o_done), .o_wo(o_world_orientation), .o_ws(o_world_scale),
        .o_wp(o_world_position), .o_ovf(o_overflow)
    );

endmodule

[hdl/cnt_prod.sv]
// Stages 1-2: products for orientation, scale, and parent-scaled local position.
module cnt_prod
    import cnt_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_ctrl        i_ctrl,
    input  logic [63:0]  i_lo,
    input  logic [47:0]  i_ls,
    input  logic [47:0]  i_lp,
    input  logic [63:0]  i_po,
    input  logic [47:0]  i_ps,
    input  logic [47:0]  i_pp,
    output t_ctrl        o_ctrl,
    output logic [63:0]  o_lo,
    output logic [47:0]  o_ls,
    output logic [47:0]  o_lp,
    output logic [63:0]  o_po,
    output logic [47:0]  o_pp,
    output logic [63:0]  o_wo,
    output logic [47:0]  o_ws,
    output logic [1:0]   o_ovf,
    output logic signed [31:0] o_s [3]
);

    t_ctrl r_c1, n_c1;
    logic [63:0] r_lo1, r_po1;
    logic [47:0] r_ls1, r_lp1, r_pp1;
    logic signed [31:0] r_qp [16];
    logic signed [31:0] r_sp [3];
    logic signed [31:0] r_s1 [3];

    t_ctrl r_c2;
    logic [63:0] r_lo2, r_po2, r_wo2;
    logic [47:0] r_ls2, r_lp2, r_pp2, r_ws2;
    logic [1:0]  r_ov2;
    logic signed [31:0] r_s2 [3];

    t_lane pq [4];
    t_lane q [4];
    logic signed [47:0] o_sum [4];
    logic [16:0] sq [4];
    logic [16:0] ss [3];
    logic [63:0] n_wo;
    logic [47:0] n_ws;
    logic [1:0]  n_ov;

    assign n_c1 = i_ctrl;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            pq[i] = i_po[63-16*i -: 16];
            q[i]  = i_lo[63-16*i -: 16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1 <= '0;
        end else begin
            r_c1 <= n_c1;
        end
        r_lo1 <= i_lo;
        r_po1 <= i_po;
        r_ls1 <= i_ls;
        r_lp1 <= i_lp;
        r_pp1 <= i_pp;
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                r_qp[4*i+j] <= pq[i] * q[j];
            end
        end
        for (int i = 0; i < 3; i++) begin
            r_sp[i] <= $signed(i_ps[47-16*i -: 16]) * $signed(i_ls[47-16*i -: 16]);
            r_s1[i] <= $signed(i_ps[47-16*i -: 16]) * $signed(i_lp[47-16*i -: 16]);
        end
    end

    always_comb begin
        o_sum[0] = 48'(r_qp[0]) - 48'(r_qp[5]) - 48'(r_qp[10]) - 48'(r_qp[15]);
        o_sum[1] = 48'(r_qp[1]) + 48'(r_qp[4]) + 48'(r_qp[11]) - 48'(r_qp[14]);
        o_sum[2] = 48'(r_qp[2]) - 48'(r_qp[7]) + 48'(r_qp[8]) + 48'(r_qp[13]);
        o_sum[3] = 48'(r_qp[3]) + 48'(r_qp[6]) - 48'(r_qp[9]) + 48'(r_qp[12]);
        for (int i = 0; i < 4; i++) begin
            sq[i] = sat16(rnd14(o_sum[i]));
        end
        for (int i = 0; i < 3; i++) begin
            ss[i] = sat16(rnd8(48'(r_sp[i])));
        end
        n_wo = {sq[0][15:0], sq[1][15:0], sq[2][15:0], sq[3][15:0]};
        n_ws = {ss[0][15:0], ss[1][15:0], ss[2][15:0]};
        n_ov[0] = sq[0][16] | sq[1][16] | sq[2][16] | sq[3][16];
        n_ov[1] = ss[0][16] | ss[1][16] | ss[2][16];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c2 <= '0;
        end else begin
            r_c2 <= r_c1;
        end
        r_lo2 <= r_lo1;
        r_po2 <= r_po1;
        r_ls2 <= r_ls1;
        r_lp2 <= r_lp1;
        r_pp2 <= r_pp1;
        r_wo2 <= n_wo;
        r_ws2 <= n_ws;
        r_ov2 <= n_ov;
        r_s2  <= r_s1;
    end

    assign o_ctrl = r_c2;
    assign o_lo   = r_lo2;
    assign o_ls   = r_ls2;
    assign o_lp   = r_lp2;
    assign o_po   = r_po2;
    assign o_pp   = r_pp2;
    assign o_wo   = r_wo2;
    assign o_ws   = r_ws2;
    assign o_ovf  = r_ov2;
    assign o_s    = r_s2;

endmodule

[hdl/cnt_rot.sv]
// Stages 3-7: quaternion rotation of the scaled position, translate, select, and output register.
module cnt_rot
    import cnt_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_ctrl        i_ctrl,
    input  logic [63:0]  i_lo,
    input  logic [47:0]  i_ls,
    input  logic [47:0]  i_lp,
    input  logic [63:0]  i_po,
    input  logic [47:0]  i_pp,
    input  logic [63:0]  i_wo,
    input  logic [47:0]  i_ws,
    input  logic [1:0]   i_ovf,
    input  logic signed [31:0] i_s [3],
    output logic         o_valid,
    output logic [63:0]  o_wo,
    output logic [47:0]  o_ws,
    output logic [47:0]  o_wp,
    output logic         o_ovf
);

    // stage 3: u x s products
    t_ctrl r_c3, r_c4, r_c5, r_c6;
    logic [63:0] r_lo3, r_lo4, r_lo5, r_lo6;
    logic [47:0] r_ls3, r_ls4, r_ls5, r_ls6;
    logic [47:0] r_lp3, r_lp4, r_lp5, r_lp6;
    logic [63:0] r_po3, r_po4;
    logic [47:0] r_pp3, r_pp4, r_pp5, r_pp6;
    logic [63:0] r_wo3, r_wo4, r_wo5, r_wo6;
    logic [47:0] r_ws3, r_ws4, r_ws5, r_ws6;
    logic [1:0]  r_ov3, r_ov4, r_ov5;
    logic        r_ov6;
    logic signed [31:0] r_s3 [3];
    logic signed [31:0] r_s4 [3];
    logic signed [31:0] r_s5 [3];
    logic signed [47:0] r_xp [6];
    logic signed [33:0] r_a4 [3];
    logic signed [47:0] r_bp [6];
    logic signed [47:0] r_cp [3];
    logic signed [47:0] r_r5 [3];

    t_lane u [3];
    t_lane u4 [3];
    t_lane w4;
    logic signed [47:0] a_c [3];
    logic signed [63:0] b_d [3];
    logic signed [47:0] b_c [3];
    logic signed [47:0] c_c [3];
    logic [16:0] sp [3];
    logic [47:0] n_wp;
    logic        n_ov;

    t_ctrl r_c7;
    logic [63:0] r_wo7;
    logic [47:0] r_ws7, r_wp7;
    logic        r_ov7;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            u[i]  = i_po[47-16*i -: 16];
            u4[i] = r_po4[47-16*i -: 16];
        end
        w4 = r_po4[63:48];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c3 <= '0;
            r_c4 <= '0;
            r_c5 <= '0;
            r_c6 <= '0;
            r_c7 <= '0;
        end else begin
            r_c3 <= i_ctrl;
            r_c4 <= r_c3;
            r_c5 <= r_c4;
            r_c6 <= r_c5;
            r_c7 <= r_c6;
        end
        r_lo3 <= i_lo;  r_lo4 <= r_lo3; r_lo5 <= r_lo4; r_lo6 <= r_lo5;
        r_ls3 <= i_ls;  r_ls4 <= r_ls3; r_ls5 <= r_ls4; r_ls6 <= r_ls5;
        r_lp3 <= i_lp;  r_lp4 <= r_lp3; r_lp5 <= r_lp4; r_lp6 <= r_lp5;
        r_po3 <= i_po;  r_po4 <= r_po3;
        r_pp3 <= i_pp;  r_pp4 <= r_pp3; r_pp5 <= r_pp4; r_pp6 <= r_pp5;
        r_wo3 <= i_wo;  r_wo4 <= r_wo3; r_wo5 <= r_wo4; r_wo6 <= r_wo5;
        r_ws3 <= i_ws;  r_ws4 <= r_ws3; r_ws5 <= r_ws4; r_ws6 <= r_ws5;
        r_ov3 <= i_ovf; r_ov4 <= r_ov3; r_ov5 <= r_ov4;
        r_s3  <= i_s;   r_s4  <= r_s3;  r_s5  <= r_s4;
        // stage 3
        r_xp[0] <= u[1] * i_s[2];
        r_xp[1] <= u[2] * i_s[1];
        r_xp[2] <= u[2] * i_s[0];
        r_xp[3] <= u[0] * i_s[2];
        r_xp[4] <= u[0] * i_s[1];
        r_xp[5] <= u[1] * i_s[0];
        // stage 4
        for (int i = 0; i < 3; i++) begin
            r_a4[i] <= 34'(a_c[i]);
        end
        // stage 5
        r_bp[0] <= u4[1] * r_a4[2];
        r_bp[1] <= u4[2] * r_a4[1];
        r_bp[2] <= u4[2] * r_a4[0];
        r_bp[3] <= u4[0] * r_a4[2];
        r_bp[4] <= u4[0] * r_a4[1];
        r_bp[5] <= u4[1] * r_a4[0];
        for (int i = 0; i < 3; i++) begin
            r_cp[i] <= w4 * r_a4[i];
        end
        // stage 6
        for (int i = 0; i < 3; i++) begin
            r_r5[i] <= 48'(r_s5[i]) + 48'(2) * (rnd14(r_cp[i]) + b_c[i]);
        end
        r_ov6 <= (r_c5.inh_ori & r_ov5[0]) | (r_c5.inh_scl & r_ov5[1]);
        // stage 7
        r_wo7 <= r_c6.has_parent && r_c6.inh_ori ? r_wo6 : r_lo6;
        r_ws7 <= r_c6.has_parent && r_c6.inh_scl ? r_ws6 : r_ls6;
        r_wp7 <= r_c6.has_parent ? n_wp : r_lp6;
        r_ov7 <= r_c6.has_parent && n_ov;
    end

    always_comb begin
        a_c[0] = rnd14(r_xp[0] - r_xp[1]);
        a_c[1] = rnd14(r_xp[2] - r_xp[3]);
        a_c[2] = rnd14(r_xp[4] - r_xp[5]);
        b_d[0] = 64'(r_bp[0]) - 64'(r_bp[1]);
        b_d[1] = 64'(r_bp[2]) - 64'(r_bp[3]);
        b_d[2] = 64'(r_bp[4]) - 64'(r_bp[5]);
        for (int i = 0; i < 3; i++) begin
            b_c[i] = 48'((b_d[i] + 64'sd8192) >>> 14);
            c_c[i] = r_r5[i] + 48'($signed(r_pp6[47-16*i -: 16])) * 48'sd256;
            sp[i]  = sat16(rnd8(c_c[i]));
        end
        n_wp = {sp[0][15:0], sp[1][15:0], sp[2][15:0]};
        n_ov = sp[0][16] | sp[1][16] | sp[2][16] | r_ov6;
    end

    assign o_valid = r_c7.valid;
    assign o_wo    = r_wo7;
    assign o_ws    = r_ws7;
    assign o_wp    = r_wp7;
    assign o_ovf   = r_ov7;

endmodule

[hdl/cnt_checker.sv]
// Checker: port-level properties of the composition core, bound to the top level.
module cnt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        i_has_parent,
    input logic        o_done,
    input logic        o_overflow
);

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("busy raised");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##7 o_done)
        else $error("result missing");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!$past(start && !busy, 7)) |-> !o_done)
        else $error("unexpected result");

    a_root_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_has_parent) |-> ##7 !o_overflow)
        else $error("overflow on root");

endmodule

bind compose_node_transform_core cnt_checker u_cnt_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .i_has_parent(i_has_parent),
    .o_done(o_done), .o_overflow(o_overflow)
);

[verif/compose_node_transform_core_test.sv]
// Self-checking testbench for the node world-transform composition core.
`timescale 1ns / 1ps

module compose_node_transform_core_test;
    import cnt_pkg::*;

    typedef struct {
        logic        has_parent;
        logic        inh_ori;
        logic        inh_scl;
        logic [63:0] lo;
        logic [47:0] ls;
        logic [47:0] lp;
        logic [63:0] po;
        logic [47:0] ps;
        logic [47:0] pp;
    } t_node;

    typedef struct {
        logic [63:0] ori;
        logic [47:0] scl;
        logic [47:0] pos;
        logic        ovf;
    } t_world;

    localparam int WATCHDOG_LIMIT = 2000;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_has_parent;
    logic        i_inherit_orientation;
    logic        i_inherit_scale;
    logic [63:0] i_local_orientation;
    logic [47:0] i_local_scale;
    logic [47:0] i_local_position;
    logic [63:0] i_parent_orientation;
    logic [47:0] i_parent_scale;
    logic [47:0] i_parent_position;
    logic        o_done;
    logic [63:0] o_world_orientation;
    logic [47:0] o_world_scale;
    logic [47:0] o_world_position;
    logic        o_overflow;

    t_node  pending_nodes[$];
    t_world expected_worlds[$];
    int     error_count = 0;
    int     idle_pct = 0;
    bit     hold_drain = 0;
    bit     drain_done = 0;
    bit     stim_done = 0;
    t_node  cur_node;
    int     accepted_count = 0;
    int     done_count = 0;

    compose_node_transform_core dut (.*);

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint lane_at(logic [63:0] word, int idx, int lanes);
        logic signed [15:0] v;
        v = word[16 * (lanes - 1 - idx) +: 16];
        return longint'(v);
    endfunction

    function automatic longint round_off(longint v, int sh);
        return (v + (longint'(1) << (sh - 1))) >>> sh;
    endfunction

    function automatic logic [15:0] clamp16(longint v, inout logic ovf);
        if (v > 32767) begin
            ovf = 1;
            return 16'h7fff;
        end
        if (v < -32768) begin
            ovf = 1;
            return 16'h8000;
        end
        return v[15:0];
    endfunction

    function automatic t_world compose_world(t_node n);
        t_world w;
        longint pq[4], q[4], o[4], s[3], u[3], a[3], b[3], c, r;
        logic ovf;
        ovf = 0;
        w.ori = n.lo;
        w.scl = n.ls;
        w.pos = n.lp;
        if (n.has_parent) begin
            for (int i = 0; i < 4; i++) pq[i] = lane_at(n.po, i, 4);
            if (n.inh_ori) begin
                for (int i = 0; i < 4; i++) q[i] = lane_at(n.lo, i, 4);
                o[0] = pq[0]*q[0] - pq[1]*q[1] - pq[2]*q[2] - pq[3]*q[3];
                o[1] = pq[0]*q[1] + pq[1]*q[0] + pq[2]*q[3] - pq[3]*q[2];
                o[2] = pq[0]*q[2] - pq[1]*q[3] + pq[2]*q[0] + pq[3]*q[1];
                o[3] = pq[0]*q[3] + pq[1]*q[2] - pq[2]*q[1] + pq[3]*q[0];
                for (int i = 0; i < 4; i++)
                    w.ori[16 * (3 - i) +: 16] = clamp16(round_off(o[i], 14), ovf);
            end
            if (n.inh_scl) begin
                for (int i = 0; i < 3; i++)
                    w.scl[16 * (2 - i) +: 16] = clamp16(round_off(
                        lane_at(n.ps, i, 3) * lane_at(n.ls, i, 3), 8), ovf);
            end
            for (int i = 0; i < 3; i++) begin
                s[i] = lane_at(n.ps, i, 3) * lane_at(n.lp, i, 3);
                u[i] = pq[i + 1];
            end
            a[0] = round_off(u[1]*s[2] - u[2]*s[1], 14);
            a[1] = round_off(u[2]*s[0] - u[0]*s[2], 14);
            a[2] = round_off(u[0]*s[1] - u[1]*s[0], 14);
            b[0] = round_off(u[1]*a[2] - u[2]*a[1], 14);
            b[1] = round_off(u[2]*a[0] - u[0]*a[2], 14);
            b[2] = round_off(u[0]*a[1] - u[1]*a[0], 14);
            for (int i = 0; i < 3; i++) begin
                c = round_off(pq[0] * a[i], 14);
                r = s[i] + 2 * (c + b[i]) + lane_at(n.pp, i, 3) * 256;
                w.pos[16 * (2 - i) +: 16] = clamp16(round_off(r, 8), ovf);
            end
        end
        w.ovf = ovf;
        return w;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    task automatic queue_node(t_node n);
        pending_nodes.insert(pending_nodes.size(), n);
    endtask

    function automatic logic [15:0] pick_lane();
        case ($urandom_range(0, 9))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'h4000;
            4: return 16'hc000;
            5: return 16'($urandom_range(0, 255));
            6: return 16'(-$urandom_range(0, 255));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [63:0] pick_quat(bit unit_like);
        logic [63:0] v;
        int k;
        for (int i = 0; i < 4; i++) v[16 * i +: 16] = pick_lane();
        if (unit_like) begin
            // one dominant lane near unit, the rest small
            v = '0;
            k = $urandom_range(0, 3);
            for (int i = 0; i < 4; i++)
                v[16 * i +: 16] = (i == k) ? 16'($urandom_range(0, 1) ? 16384 : -16384)
                                           : 16'($signed($urandom_range(0, 8000)) - 4000);
        end
        return v;
    endfunction

    function automatic t_node random_node(bit full_range);
        t_node n;
        n.has_parent = ($urandom_range(0, 9) != 0);
        n.inh_ori = $urandom_range(0, 1);
        n.inh_scl = $urandom_range(0, 1);
        n.lo = full_range ? {$urandom, $urandom} : pick_quat($urandom_range(0, 2) != 0);
        n.po = full_range ? {$urandom, $urandom} : pick_quat($urandom_range(0, 2) != 0);
        for (int i = 0; i < 3; i++) begin
            n.ls[16 * i +: 16] = full_range ? 16'($urandom) : pick_lane();
            n.lp[16 * i +: 16] = full_range ? 16'($urandom) : pick_lane();
            n.ps[16 * i +: 16] = full_range ? 16'($urandom) : pick_lane();
            n.pp[16 * i +: 16] = full_range ? 16'($urandom) : pick_lane();
        end
        return n;
    endfunction

    function automatic t_node fixed_node(bit hp, bit io, bit is, logic [15:0] v, logic [15:0] p);
        t_node n;
        n.has_parent = hp;
        n.inh_ori = io;
        n.inh_scl = is;
        n.lo = {4{v}};
        n.ls = {3{v}};
        n.lp = {3{v}};
        n.po = {4{p}};
        n.ps = {3{p}};
        n.pp = {3{p}};
        return n;
    endfunction

    initial begin
        t_node n;
        // extremes, flag combinations, root pass-through, non-unit saturation
        for (int f = 0; f < 8; f++) begin
            queue_node(fixed_node(f[2], f[1], f[0], 16'h7fff, 16'h7fff));
            queue_node(fixed_node(f[2], f[1], f[0], 16'h8000, 16'h8000));
        end
        queue_node(fixed_node(1, 1, 1, 16'h7fff, 16'h8000));
        queue_node(fixed_node(1, 1, 1, 16'h0000, 16'h0000));
        queue_node(fixed_node(1, 1, 1, 16'hffff, 16'hffff));
        n = fixed_node(1, 1, 1, 16'h0100, 16'h0100);
        n.po = 64'h4000_0000_0000_0000;
        queue_node(n);
        n.po = 64'h2d41_2d41_0000_0000;
        queue_node(n);
        for (int i = 0; i < 1950; i++)
            queue_node(random_node($urandom_range(0, 4) == 0));
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 0;
        end else if (!(start && busy)) begin
            if (start) begin
                n_accepted: begin
                    expected_worlds.insert(expected_worlds.size(), compose_world(cur_node));
                    accepted_count++;
                end
            end
            if (pending_nodes.size() == 0 || hold_drain ||
                    (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct)) begin
                start <= 0;
                if (pending_nodes.size() == 0) stim_done <= 1;
            end else begin
                cur_node = pending_nodes[0];
                pending_nodes.delete(0);
                start <= 1;
                i_has_parent <= cur_node.has_parent;
                i_inherit_orientation <= cur_node.inh_ori;
                i_inherit_scale <= cur_node.inh_scl;
                i_local_orientation <= cur_node.lo;
                i_local_scale <= cur_node.ls;
                i_local_position <= cur_node.lp;
                i_parent_orientation <= cur_node.po;
                i_parent_scale <= cur_node.ps;
                i_parent_position <= cur_node.pp;
            end
        end
    end

    always @(posedge i_clk) begin
        t_world want;
        if (i_rst_n && o_done) begin
            done_count++;
            if (expected_worlds.size() == 0) begin
                report_mismatch("unexpected result", 0, 0);
            end else begin
                want = expected_worlds[0];
                expected_worlds.delete(0);
                if (o_world_orientation !== want.ori)
                    report_mismatch("orientation", o_world_orientation, want.ori);
                if (o_world_scale !== want.scl)
                    report_mismatch("scale", o_world_scale, want.scl);
                if (o_world_position !== want.pos)
                    report_mismatch("position", o_world_position, want.pos);
                if (o_overflow !== want.ovf)
                    report_mismatch("overflow", o_overflow, want.ovf);
            end
        end
    end

    initial begin
        int quiet;
        int last_acc, last_done;
        i_rst_n = 0;
        start = 0;
        i_has_parent = 0;
        i_inherit_orientation = 0;
        i_inherit_scale = 0;
        i_local_orientation = '0;
        i_local_scale = '0;
        i_local_position = '0;
        i_parent_orientation = '0;
        i_parent_scale = '0;
        i_parent_position = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        quiet = 0;
        last_acc = 0;
        last_done = 0;
        while (!stim_done || expected_worlds.size() != 0 || start) begin
            @(posedge i_clk);
            case ((accepted_count / 250) % 4)
                0: idle_pct <= 0;
                1: idle_pct <= 60;
                2: idle_pct <= 0;
                default: idle_pct <= 20;
            endcase
            // drain the pipeline once mid-run
            if (accepted_count >= 600 && !drain_done && !hold_drain)
                hold_drain <= 1;
            if (hold_drain && !start && expected_worlds.size() == 0) begin
                hold_drain <= 0;
                drain_done <= 1;
            end
            if (accepted_count != last_acc || done_count != last_done) quiet = 0;
            else quiet++;
            last_acc = accepted_count;
            last_done = done_count;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
        repeat (20) @(posedge i_clk);
        if (error_count == 0 && expected_worlds.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[compose_node_transform_core.f]
hdl/cnt_pkg.sv
hdl/cnt_prod.sv
hdl/cnt_rot.sv
hdl/compose_node_transform_core.sv
hdl/cnt_checker.sv
verif/compose_node_transform_core_test.sv
